FILE: rtl/smci_pkg.sv
// shared types, constants and helper functions of the motor command interpreter
package smci_pkg;

  // default line buffer depth
  localparam int unsigned LINE_DEPTH_DEF = 32;

  // console control characters
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR_HI = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // motor link frame bytes
  localparam logic [7:0] FRM_SYNC     = 8'h01;
  localparam logic [7:0] FRM_CMD_MODE = 8'hA0;
  localparam logic [7:0] FRM_CMD_DATA = 8'h64;
  localparam logic [7:0] FRM_MODE_VEL = 8'h02;
  localparam logic [7:0] FRM_MODE_POS = 8'h03;
  localparam logic [3:0] FRM_LAST_IDX = 4'd9;
  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [15:0] ANGLE_SCALE = 16'd91;

  // console text: crlf + error, syntax error, backspace erase
  localparam int unsigned TEXT_LEN = 44;
  localparam logic [8*TEXT_LEN-1:0] TEXT_ROM =
    "\015\012command error.\015\012command syntax error.\015\012\010 \010";
  localparam logic [5:0] TXT_CRLF_END  = 6'd1;
  localparam logic [5:0] TXT_ERR_END   = 6'd17;
  localparam logic [5:0] TXT_SYN_START = 6'd18;
  localparam logic [5:0] TXT_SYN_END   = 6'd40;
  localparam logic [5:0] TXT_BS_START  = 6'd41;
  localparam logic [5:0] TXT_BS_END    = 6'd43;
  localparam logic [2:0] SCAN_LAST     = 3'd5;

  // command prefixes
  typedef enum logic [1:0] {
    PAT_VEL,
    PAT_ANGLE,
    PAT_STOP
  } pat_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_FOUR,
    IDX_SIX,
    IDX_INC
  } idx_op_e;

  typedef enum logic [2:0] {
    VAL_HOLD,
    VAL_CLR,
    VAL_DIG,
    VAL_NEG,
    VAL_MUL
  } val_op_e;

  typedef enum logic [1:0] {
    SRC_CHAR,
    SRC_TEXT,
    SRC_FRAME
  } src_e;

  // controller to datapath
  typedef struct packed {
    logic      store;
    logic      len_dec;
    logic      len_clr;
    idx_op_e   idx_op;
    logic      match_init;
    logic      match_step;
    val_op_e   val_op;
    logic      sign_set;
    logic      push;
    src_e      src;
    logic [5:0] txt_idx;
    logic [3:0] frm_idx;
    logic      frm_mode;
    logic      frm_angle;
    logic      last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic len_zero;
    logic rx_cr;
    logic rx_bs;
    logic rx_lf;
    logic idx_lt_len;
    logic is_space;
    logic is_sign;
    logic is_digit;
    logic vel_ok;
    logic ang_ok;
    logic stop_ok;
    logic push_ok;
  } status_t;

  function automatic logic [7:0] text_byte(input logic [5:0] i);
    return TEXT_ROM[(TEXT_LEN - 1 - int'(i)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] pat_byte(input pat_e p, input logic [2:0] i);
    logic [7:0] b;
    b = 8'h00;
    case (p)
      PAT_VEL: begin
        case (i)
          3'd0: b = "v";
          3'd1: b = "e";
          3'd2: b = "l";
          3'd3: b = ":";
          default: b = 8'h00;
        endcase
      end
      PAT_ANGLE: begin
        case (i)
          3'd0: b = "a";
          3'd1: b = "n";
          3'd2: b = "g";
          3'd3: b = "l";
          3'd4: b = "e";
          3'd5: b = ":";
          default: b = 8'h00;
        endcase
      end
      PAT_STOP: begin
        case (i)
          3'd0: b = "s";
          3'd1: b = "t";
          3'd2: b = "o";
          3'd3: b = "p";
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one byte of crc-8 reflected, poly 0x31
  function automatic logic [7:0] crc_upd(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/smci_if.sv
// item channels: received characters in, transmit bytes out
interface smci_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface smci_tx_if;
  logic       valid;
  logic       ready;
  logic       port;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output port, output out_byte, output last, input ready);
  modport sink (input valid, input port, input out_byte, input last, output ready);
endinterface

FILE: rtl/serial_motor_command_interpreter.sv
// top level of the serial motor command interpreter
//
//   channel  dir  payload                       use
//   rx_i     in   rx_char[7:0]                  console character
//   tx_o     out  port, out_byte[7:0], last     console or motor link byte
//
// a carriage return scans 6 line bytes through the line memory read port,
// parses the number bytes, then sends one byte per cycle while tx_o is
// ready (up to 25 bytes). reset clears the line length, the output valid
// flag and the controller state; the line memory needs no clearing.
// a stalled tx_o holds the controller; rx_i is ready only when idle.
module serial_motor_command_interpreter #(
  parameter int unsigned LINE_DEPTH = smci_pkg::LINE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smci_rx_if.sink   rx_i,
  smci_tx_if.source tx_o
);
  import smci_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign rx_i.ready = in_ready;

  smci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smci_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_char_i (rx_i.valid ? rx_i.rx_char : 8'h00),
    .cmd_i     (cmd),
    .status_o  (status),
    .tx_o      (tx_o)
  );

  // a character is stored only below the full mark
  a_store_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> !status.full) else $error("store into full line");

  // backspace never underflows the length
  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.len_dec |-> !status.len_zero) else $error("length underflow");

  // no result is produced while new items are taken
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !in_ready) else $error("push while idle");

  // the final result of an item returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push && status.push_ok && cmd.last) |=> in_ready) else $error("no idle after last");

endmodule

FILE: rtl/smci_dp.sv
// datapath: line memory, length, matcher, number parser, crc and output register
module smci_dp #(
  parameter int unsigned LINE_DEPTH = smci_pkg::LINE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_char_i,
  input  smci_pkg::cmd_t      cmd_i,
  output smci_pkg::status_t   status_o,
  smci_tx_if.source           tx_o
);
  import smci_pkg::*;

  localparam int unsigned IDX_W = $clog2(LINE_DEPTH);

  logic [7:0]       mem [LINE_DEPTH];
  logic [7:0]       rd_q;
  logic [7:0]       char_q;
  logic [IDX_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      val_q, val_d;
  logic             neg_q;
  logic             vel_q, ang_q, stop_q;
  logic [7:0]       crc_q;
  logic             out_valid_q;
  logic             port_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             push_ok;
  logic             idx_lt_len;
  logic [7:0]       push_byte;
  logic             push_port;
  logic [2:0]       idx3;

  assign idx3       = idx_q[2:0];
  assign idx_lt_len = idx_q < len_q;
  assign push_ok    = !out_valid_q || tx_o.ready;

  // status toward the controller
  always_comb begin
    status_o.full       = len_q == IDX_W'(LINE_DEPTH - 1);
    status_o.len_zero   = len_q == '0;
    status_o.rx_cr      = rx_char_i == CHAR_CR;
    status_o.rx_bs      = rx_char_i == CHAR_BS;
    status_o.rx_lf      = rx_char_i == CHAR_LF;
    status_o.idx_lt_len = idx_lt_len;
    status_o.is_space   = (rd_q == CHAR_SPACE) || (rd_q >= CHAR_TAB && rd_q <= CHAR_CR_HI);
    status_o.is_sign    = (rd_q == CHAR_PLUS) || (rd_q == CHAR_MINUS);
    status_o.is_digit   = rd_q >= CHAR_ZERO && rd_q <= CHAR_NINE;
    status_o.vel_ok     = vel_q;
    status_o.ang_ok     = ang_q;
    status_o.stop_ok    = stop_q;
    status_o.push_ok    = push_ok;
  end

  // line length
  always_comb begin
    len_d = len_q;
    if (cmd_i.len_clr) begin
      len_d = '0;
    end else if (cmd_i.store) begin
      len_d = len_q + 1'b1;
    end else if (cmd_i.len_dec) begin
      len_d = len_q - 1'b1;
    end
  end

  // scan and parse index
  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_FOUR: idx_d = IDX_W'(4);
      IDX_SIX:  idx_d = IDX_W'(6);
      IDX_INC:  idx_d = idx_q + 1'b1;
      default:  idx_d = idx_q;
    endcase
  end

  // parsed value
  always_comb begin
    case (cmd_i.val_op)
      VAL_CLR: val_d = '0;
      VAL_DIG: val_d = (val_q << 3) + (val_q << 1) + {12'd0, rd_q[3:0]};
      VAL_NEG: val_d = neg_q ? (16'd0 - val_q) : val_q;
      VAL_MUL: val_d = 16'(val_q * ANGLE_SCALE);
      default: val_d = val_q;
    endcase
  end

  // byte selection for the next result item
  always_comb begin
    push_byte = 8'h00;
    push_port = 1'b0;
    case (cmd_i.src)
      SRC_CHAR: push_byte = char_q;
      SRC_TEXT: push_byte = text_byte(cmd_i.txt_idx);
      SRC_FRAME: begin
        push_port = 1'b1;
        case (cmd_i.frm_idx)
          4'd0: push_byte = FRM_SYNC;
          4'd1: push_byte = cmd_i.frm_mode ? FRM_CMD_MODE : FRM_CMD_DATA;
          4'd2: push_byte = cmd_i.frm_mode ? 8'h00 : val_q[15:8];
          4'd3: push_byte = cmd_i.frm_mode ? 8'h00 : val_q[7:0];
          FRM_LAST_IDX: begin
            if (cmd_i.frm_mode) begin
              push_byte = cmd_i.frm_angle ? FRM_MODE_POS : FRM_MODE_VEL;
            end else begin
              push_byte = crc_q;
            end
          end
          default: push_byte = 8'h00;
        endcase
      end
      default: push_byte = 8'h00;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.push && push_ok) begin
        out_valid_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[len_q] <= rx_char_i;
    end
    rd_q <= mem[idx_q];
  end

  // working registers and output payload
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    if (cmd_i.store) begin
      char_q <= rx_char_i;
    end
    if (cmd_i.val_op == VAL_CLR) begin
      neg_q <= 1'b0;
    end else if (cmd_i.sign_set) begin
      neg_q <= rd_q == CHAR_MINUS;
    end
    if (cmd_i.match_init) begin
      vel_q  <= 1'b1;
      ang_q  <= 1'b1;
      stop_q <= 1'b1;
    end else if (cmd_i.match_step) begin
      vel_q  <= vel_q && ((idx3 >= 3'd4) || (idx_lt_len && rd_q == pat_byte(PAT_VEL, idx3)));
      ang_q  <= ang_q && (idx_lt_len && rd_q == pat_byte(PAT_ANGLE, idx3));
      stop_q <= stop_q && ((idx3 >= 3'd4) || (idx_lt_len && rd_q == pat_byte(PAT_STOP, idx3)));
    end
    if (cmd_i.push && push_ok) begin
      port_q <= push_port;
      byte_q <= push_byte;
      last_q <= cmd_i.last;
      if (cmd_i.src == SRC_FRAME && cmd_i.frm_idx != FRM_LAST_IDX) begin
        crc_q <= crc_upd((cmd_i.frm_idx == 4'd0) ? 8'h00 : crc_q, push_byte);
      end
    end
  end

  assign tx_o.valid    = out_valid_q;
  assign tx_o.port     = port_q;
  assign tx_o.out_byte = byte_q;
  assign tx_o.last     = last_q;

endmodule

FILE: rtl/smci_ctrl.sv
// controller: sequences echo, line matching, number parsing and frame output
module smci_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smci_pkg::status_t status_i,
  output smci_pkg::cmd_t    cmd_o
);
  import smci_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHAR,
    S_BSE,
    S_ERR,
    S_SC_RD,
    S_SC_EV,
    S_DECIDE,
    S_P_RD,
    S_P_EV,
    S_NEG,
    S_MUL,
    S_CRLF,
    S_SYN,
    S_MODE,
    S_DATA
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_VEL,
    ACT_ANG,
    ACT_STOP,
    ACT_SYN
  } act_e;

  state_e     state_q, state_d;
  act_e       act_q, act_d;
  logic [5:0] t_q, t_d;
  logic [3:0] f_q, f_d;
  logic       dig_q, dig_d;

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    t_d        = t_q;
    f_d        = f_q;
    dig_d      = dig_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.txt_idx   = t_q;
    cmd_o.frm_idx   = f_q;
    cmd_o.frm_angle = act_q == ACT_ANG;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.full) begin
            cmd_o.len_clr = 1'b1;
            t_d     = '0;
            state_d = S_ERR;
          end else if (status_i.rx_cr) begin
            cmd_o.idx_op     = IDX_ZERO;
            cmd_o.match_init = 1'b1;
            t_d     = '0;
            state_d = S_SC_RD;
          end else if (status_i.rx_bs) begin
            if (!status_i.len_zero) begin
              cmd_o.len_dec = 1'b1;
              t_d     = TXT_BS_START;
              state_d = S_BSE;
            end
          end else if (!status_i.rx_lf) begin
            cmd_o.store = 1'b1;
            state_d     = S_CHAR;
          end
        end
      end
      S_CHAR: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_CHAR;
        cmd_o.last = 1'b1;
        if (status_i.push_ok) begin
          state_d = S_IDLE;
        end
      end
      S_BSE, S_ERR, S_CRLF, S_SYN: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_TEXT;
        if (state_q == S_CRLF) begin
          cmd_o.len_clr = 1'b1;
          cmd_o.last    = (t_q == TXT_CRLF_END) && (act_q == ACT_NONE);
        end else begin
          cmd_o.last = (t_q == TXT_BS_END) || (t_q == TXT_ERR_END && state_q == S_ERR) ||
                       (t_q == TXT_SYN_END);
        end
        if (status_i.push_ok) begin
          t_d = t_q + 6'd1;
          if (state_q == S_CRLF && t_q == TXT_CRLF_END) begin
            f_d = '0;
            case (act_q)
              ACT_SYN: begin
                t_d     = TXT_SYN_START;
                state_d = S_SYN;
              end
              ACT_VEL, ACT_ANG: state_d = S_MODE;
              ACT_STOP: state_d = S_DATA;
              default: state_d = S_IDLE;
            endcase
          end else if (cmd_o.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SC_RD: state_d = S_SC_EV;
      S_SC_EV: begin
        cmd_o.match_step = 1'b1;
        if (t_q[2:0] == SCAN_LAST) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          t_d     = t_q + 6'd1;
          state_d = S_SC_RD;
        end
      end
      S_DECIDE: begin
        t_d   = '0;
        dig_d = 1'b0;
        cmd_o.val_op = VAL_CLR;
        if (status_i.vel_ok) begin
          act_d        = ACT_VEL;
          cmd_o.idx_op = IDX_FOUR;
          state_d      = S_P_RD;
        end else if (status_i.ang_ok) begin
          act_d        = ACT_ANG;
          cmd_o.idx_op = IDX_SIX;
          state_d      = S_P_RD;
        end else if (status_i.stop_ok) begin
          act_d   = ACT_STOP;
          state_d = S_CRLF;
        end else if (!status_i.len_zero) begin
          act_d   = ACT_SYN;
          state_d = S_CRLF;
        end else begin
          act_d   = ACT_NONE;
          state_d = S_CRLF;
        end
      end
      S_P_RD: state_d = S_P_EV;
      S_P_EV: begin
        state_d = S_NEG;
        if (status_i.idx_lt_len) begin
          if (!dig_q && status_i.is_space) begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_P_RD;
          end else if (!dig_q && status_i.is_sign) begin
            cmd_o.sign_set = 1'b1;
            cmd_o.idx_op   = IDX_INC;
            dig_d          = 1'b1;
            state_d        = S_P_RD;
          end else if (status_i.is_digit) begin
            cmd_o.val_op = VAL_DIG;
            cmd_o.idx_op = IDX_INC;
            dig_d        = 1'b1;
            state_d      = S_P_RD;
          end
        end
      end
      S_NEG: begin
        cmd_o.val_op = VAL_NEG;
        t_d          = '0;
        state_d      = (act_q == ACT_ANG) ? S_MUL : S_CRLF;
      end
      S_MUL: begin
        cmd_o.val_op = VAL_MUL;
        t_d          = '0;
        state_d      = S_CRLF;
      end
      S_MODE, S_DATA: begin
        cmd_o.push     = 1'b1;
        cmd_o.src      = SRC_FRAME;
        cmd_o.frm_mode = state_q == S_MODE;
        cmd_o.last     = (state_q == S_DATA) && (f_q == FRM_LAST_IDX);
        if (status_i.push_ok) begin
          f_d = f_q + 4'd1;
          if (f_q == FRM_LAST_IDX) begin
            f_d     = '0;
            state_d = (state_q == S_MODE) ? S_DATA : S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_NONE;
      t_q     <= '0;
      f_q     <= '0;
      dig_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      t_q     <= t_d;
      f_q     <= f_d;
      dig_q   <= dig_d;
    end
  end

endmodule

FILE: tb/serial_motor_command_interpreter_tb.sv
// self-checking testbench of the serial motor command interpreter
module serial_motor_command_interpreter_tb;
  import smci_pkg::*;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned LIMIT      = 600000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_WAIT = 120;

  typedef struct packed {
    logic       port;
    logic [7:0] out_byte;
    logic       last;
  } tx_item_t;

  logic clk_i;
  logic rst_ni;

  smci_rx_if rx_if ();
  smci_tx_if tx_if ();

  serial_motor_command_interpreter #(.LINE_DEPTH(DEPTH)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .tx_o   (tx_if.source)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  logic [7:0]  char_q[$];
  tx_item_t    tx_exp_q[$];
  logic [7:0]  line_buf[DEPTH];
  int unsigned line_len;
  int unsigned err_cnt;
  int unsigned accepted_cnt;
  bit          took;

  // line state helpers
  task automatic clear_line();
    for (int i = 0; i < DEPTH; i++) line_buf[i] = 8'h00;
    line_len = 0;
  endtask

  task automatic push_byte(input logic p, input logic [7:0] b);
    tx_exp_q.push_back('{port: p, out_byte: b, last: 1'b0});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(1'b0, s[i]);
  endtask

  function automatic logic [7:0] crc8_maxim(input logic [7:0] f[9]);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 9; i++) begin
      c ^= f[i];
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit line_starts(input string p);
    for (int i = 0; i < p.len(); i++) begin
      if (i >= line_len || line_buf[i] != p[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // atol-like parse, kept to 16 bits
  function automatic logic [15:0] line_number(input int unsigned pos);
    logic [15:0] v;
    bit          neg;
    logic [7:0]  c;
    v = 16'd0;
    neg = 1'b0;
    while (pos < line_len) begin
      c = line_buf[pos];
      if (c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13)) pos++;
      else break;
    end
    if (pos < line_len && (line_buf[pos] == CHAR_PLUS || line_buf[pos] == CHAR_MINUS)) begin
      neg = (line_buf[pos] == CHAR_MINUS);
      pos++;
    end
    while (pos < line_len && line_buf[pos] >= CHAR_ZERO && line_buf[pos] <= CHAR_NINE) begin
      v = v * 16'd10 + 16'(line_buf[pos] - CHAR_ZERO);
      pos++;
    end
    if (neg) v = 16'd0 - v;
    return v;
  endfunction

  task automatic push_mode_frame(input logic [7:0] mode);
    push_byte(1'b1, FRM_SYNC);
    push_byte(1'b1, FRM_CMD_MODE);
    for (int i = 0; i < 7; i++) push_byte(1'b1, 8'h00);
    push_byte(1'b1, mode);
  endtask

  task automatic push_data_frame(input logic [15:0] v);
    logic [7:0] f[9];
    for (int i = 0; i < 9; i++) f[i] = 8'h00;
    f[0] = FRM_SYNC;
    f[1] = FRM_CMD_DATA;
    f[2] = v[15:8];
    f[3] = v[7:0];
    for (int i = 0; i < 9; i++) push_byte(1'b1, f[i]);
    push_byte(1'b1, crc8_maxim(f));
  endtask

  // expected bytes for one received character
  task automatic predict_char(input logic [7:0] c);
    int unsigned n0;
    tx_item_t    t;
    n0 = tx_exp_q.size();
    if (line_len >= DEPTH - 1) begin
      push_text("\015\012command error.\015\012");
      clear_line();
    end else if (c == CHAR_CR) begin
      push_text("\015\012");
      if (line_starts("vel:")) begin
        push_mode_frame(FRM_MODE_VEL);
        push_data_frame(line_number(4));
      end else if (line_starts("angle:")) begin
        push_mode_frame(FRM_MODE_POS);
        push_data_frame(line_number(6) * ANGLE_SCALE);
      end else if (line_starts("stop")) begin
        push_data_frame(16'd0);
      end else if (line_len != 0) begin
        push_text("command syntax error.\015\012");
      end
      clear_line();
    end else if (c == CHAR_BS) begin
      if (line_len >= 1) begin
        line_len--;
        line_buf[line_len] = 8'h00;
        push_byte(1'b0, CHAR_BS);
        push_byte(1'b0, CHAR_SPACE);
        push_byte(1'b0, CHAR_BS);
      end
    end else if (c != CHAR_LF) begin
      line_buf[line_len] = c;
      line_len++;
      push_byte(1'b0, c);
    end
    if (tx_exp_q.size() > n0) begin
      t = tx_exp_q.pop_back();
      t.last = 1'b1;
      tx_exp_q.push_back(t);
    end
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  function automatic string rand_num();
    string sg;
    int unsigned r;
    r = $urandom_range(0, 9);
    sg = (r == 0) ? "-" : (r == 1) ? "+" : (r == 2) ? " \t" : "";
    r = $urandom_range(0, 3);
    if (r == 0) return {sg, $sformatf("%0d", $urandom_range(0, 9))};
    if (r == 1) return {sg, $sformatf("%0d", $urandom_range(0, 400))};
    if (r == 2) return {sg, $sformatf("%0d", $urandom_range(0, 32767))};
    return {sg, $sformatf("%0d", $urandom_range(0, 999999))};
  endfunction

  // stimulus
  initial begin
    int unsigned k;
    clear_line();
    // directed part
    queue_str("\010\012vel:32767\015");
    queue_str("angle:-1\015");
    queue_str("stopx\015");
    queue_str("q\010\015\015");
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    queue_str("\015");
    for (int i = 0; i < DEPTH; i++) char_q.push_back(8'h41);
    queue_str("\015");
    // random part
    while (char_q.size() < 150) begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1, 2: queue_str({"vel:", rand_num()});
        3, 4:    queue_str({"angle:", rand_num()});
        5:       queue_str((($urandom_range(0, 1)) != 0) ? "stop" : "stop 1");
        6: begin
          for (int i = $urandom_range(1, 6); i > 0; i--)
            char_q.push_back(8'($urandom_range(0, 255)));
        end
        7: begin
          queue_str("ve");
          char_q.push_back(CHAR_BS);
          queue_str((($urandom_range(0, 1)) != 0) ? "el:" : "x");
          queue_str(rand_num());
        end
        8: begin
          for (int i = $urandom_range(28, 34); i > 0; i--)
            char_q.push_back(8'($urandom_range(32, 126)));
        end
        default: queue_str("\012");
      endcase
      if ($urandom_range(0, 7) != 0) char_q.push_back(CHAR_CR);
    end
    char_q.push_back(CHAR_CR);
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.rx_char = 8'h00;
    tx_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // input acceptance and prediction
  always @(posedge clk_i) begin
    if (rst_ni && rx_if.valid && rx_if.ready) begin
      predict_char(rx_if.rx_char);
      void'(char_q.pop_front());
      accepted_cnt <= accepted_cnt + 1;
      took = 1'b1;
    end
  end

  // driver: bursts with gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!rx_if.valid || took)) begin
      took = 1'b0;
      if (gap_left > 0) begin
        rx_if.valid <= 1'b0;
        gap_left--;
      end else if (char_q.size() > 0) begin
        rx_if.valid <= 1'b1;
        rx_if.rx_char <= char_q[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
        end else begin
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
        end
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && accepted_cnt >= 60) begin
        tx_if.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
          0:       tx_if.ready <= 1'b1;
          1:       tx_if.ready <= ($urandom_range(0, 1) != 0);
          default: tx_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tx_item_t e;
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      if (tx_exp_q.size() == 0) begin
        $error("unexpected byte port=%0d byte=%h last=%0d",
               tx_if.port, tx_if.out_byte, tx_if.last);
        err_cnt++;
      end else begin
        e = tx_exp_q.pop_front();
        if (tx_if.port !== e.port) begin
          $error("port: expected %0d actual %0d", e.port, tx_if.port);
          err_cnt++;
        end
        if (tx_if.out_byte !== e.out_byte) begin
          $error("out_byte: expected %h actual %h", e.out_byte, tx_if.out_byte);
          err_cnt++;
        end
        if (tx_if.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, tx_if.last);
          err_cnt++;
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    int unsigned cyc;
    err_cnt = 0;
    accepted_cnt = 0;
    cyc = 0;
    @(posedge rst_ni);
    while (char_q.size() != 0 || tx_exp_q.size() != 0) begin
      @(posedge clk_i);
      cyc++;
      if (cyc > LIMIT) begin
        $display("serial_motor_command_interpreter: mismatch");
        $finish;
      end
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && tx_exp_q.size() == 0) begin
      $display("serial_motor_command_interpreter: match");
    end else begin
      $display("serial_motor_command_interpreter: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/smci_pkg.sv
rtl/smci_if.sv
rtl/smci_dp.sv
rtl/smci_ctrl.sv
rtl/serial_motor_command_interpreter.sv
tb/serial_motor_command_interpreter_tb.sv
